>>> design/u8v_pkg.sv
// ----------------------------------------------------------------------------
// u8v_pkg
// Types and byte-range constants for the UTF-8 validator.
// ----------------------------------------------------------------------------
package u8v_pkg;

    localparam logic [7:0] ASCII_MAX    = 8'h7F;
    localparam logic [7:0] BAD_LEAD_MIN = 8'h80;
    localparam logic [7:0] BAD_LEAD_MAX = 8'hC1;
    localparam logic [7:0] LEAD2_MIN    = 8'hC2;
    localparam logic [7:0] LEAD2_MAX    = 8'hDF;
    localparam logic [7:0] LEAD3_MIN    = 8'hE0;
    localparam logic [7:0] LEAD3_MAX    = 8'hEF;
    localparam logic [7:0] LEAD4_MIN    = 8'hF0;
    localparam logic [7:0] LEAD4_MAX    = 8'hF4;

    localparam logic [1:0] CONT_TAG = 2'b10;
    localparam logic [7:0] TERMINATOR = 8'h00;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_LEAD2 = 2'd1;
    localparam logic [1:0] PEND_LEAD3 = 2'd2;
    localparam logic [1:0] PEND_LEAD4 = 2'd3;

    typedef struct packed {
        logic [1:0] pending;
        logic       long_seen;
        logic       error_seen;
        logic       cur_long;
    } state_t;

    typedef struct packed {
        logic verdict;
        logic malformed;
        logic saw_long_sequence;
    } result_t;

endpackage

>>> design/utf8_validate_min_three_byte.sv
// ----------------------------------------------------------------------------
// utf8_validate_min_three_byte: UTF-8 check of zero-terminated byte strings.
// The terminator beat is registered in the input stage, then its verdict in the result register.
// Throughput: one byte beat per cycle; stalls only when a result is held.
// Reset: asynchronous, clears scan state and both valid stages.
// ----------------------------------------------------------------------------
module utf8_validate_min_three_byte
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] text_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       verdict,
    output logic       malformed,
    output logic       saw_long_sequence
);
    import u8v_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    res_next;
    result_t    res_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       is_term;
    logic       advance;

    u8v_step u_step
    (
        .cur       (state_reg),
        .text_byte (in_byte_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    assign out_free   = !out_valid_reg || !result_stall;
    assign is_term    = (in_byte_reg == TERMINATOR);
    // only a terminator needs the result register
    assign advance    = in_valid_reg && (!is_term || out_free);
    assign byte_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (!byte_stall)
                in_valid_reg <= byte_valid;
            if (advance)
                state_reg <= state_next;
            if (out_free)
                out_valid_reg <= advance && is_term;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
            in_byte_reg <= text_byte;
        if (advance && is_term && out_free)
            res_reg <= res_next;
    end

    assign result_valid      = out_valid_reg;
    assign verdict           = res_reg.verdict;
    assign malformed         = res_reg.malformed;
    assign saw_long_sequence = res_reg.saw_long_sequence;

`ifndef SYNTHESIS
    a_err_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.error_seen |-> state_reg.pending == PEND_NONE)
        else $error("error state with open sequence");

    a_long_open: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cur_long |-> state_reg.pending != PEND_NONE)
        else $error("long flag without open sequence");

    a_stall_on_term: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> in_valid_reg && is_term && out_valid_reg)
        else $error("byte stall without held terminator");

    a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && verdict |-> !malformed && saw_long_sequence)
        else $error("verdict set on bad string");
`endif

endmodule

>>> design/u8v_step.sv
// ----------------------------------------------------------------------------
// u8v_step
// Per-byte decode: next scan state and end-of-string verdict.
// ----------------------------------------------------------------------------
module u8v_step
(
    input  u8v_pkg::state_t  cur,
    input  logic [7:0]       text_byte,
    output u8v_pkg::state_t  nxt,
    output u8v_pkg::result_t res
);
    import u8v_pkg::*;

    logic bad;
    logic [1:0] pend_dec;

    assign bad      = cur.error_seen || (cur.pending != PEND_NONE);
    assign pend_dec = cur.pending - 2'd1;

    always_comb
    begin
        res.verdict           = !bad && cur.long_seen;
        res.malformed         = bad;
        res.saw_long_sequence = cur.long_seen;

        nxt = cur;
        if (text_byte == TERMINATOR)
        begin
            nxt = '0;
        end
        else if (cur.error_seen)
        begin
            nxt = cur;
        end
        else if (cur.pending != PEND_NONE)
        begin
            if (text_byte[7:6] != CONT_TAG)
            begin
                // not a continuation byte; it is not retried as a lead
                nxt.error_seen = 1'b1;
                nxt.pending    = PEND_NONE;
                nxt.cur_long   = 1'b0;
            end
            else
            begin
                nxt.pending = pend_dec;
                if (pend_dec == PEND_NONE)
                begin
                    nxt.long_seen = cur.long_seen | cur.cur_long;
                    nxt.cur_long  = 1'b0;
                end
            end
        end
        else if (text_byte inside {[BAD_LEAD_MIN:BAD_LEAD_MAX]})
        begin
            nxt.error_seen = 1'b1;
        end
        else if (text_byte inside {[LEAD2_MIN:LEAD2_MAX]})
        begin
            nxt.pending  = PEND_LEAD2;
            nxt.cur_long = 1'b0;
        end
        else if (text_byte inside {[LEAD3_MIN:LEAD3_MAX]})
        begin
            nxt.pending  = PEND_LEAD3;
            nxt.cur_long = 1'b1;
        end
        else if (text_byte inside {[LEAD4_MIN:LEAD4_MAX]})
        begin
            nxt.pending  = PEND_LEAD4;
            nxt.cur_long = 1'b1;
        end
        else if (text_byte > LEAD4_MAX)
        begin
            nxt.error_seen = 1'b1;
        end
        else
        begin
            nxt = cur;  // plain ASCII, 0x01 up to ASCII_MAX
        end
    end

endmodule

>>> bench/tb_utf8_validate_min_three_byte.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_validate_min_three_byte
// Feeds zero-terminated byte strings through the UTF-8 checker and compares
// each verdict beat with a scan of the same bytes kept alongside the block.
// Directed strings cover the lead ranges and the failure cases; random strings
// are mostly well formed, with noise bytes and cut sequences mixed in.
// ----------------------------------------------------------------------------
module tb_utf8_validate_min_three_byte;

    import u8v_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int RESET_TICKS = 7;
    localparam int IDLE_PCT    = 21;
    localparam int HOLD_TICKS  = 80;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_TICKS  = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    logic [7:0] text_byte = 8'h00;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic       verdict;
    logic       malformed;
    logic       saw_long_sequence;

    logic [7:0] byte_feed[$];
    result_t    verdicts_due[$];

    // scan state of the string now streaming in
    logic [1:0] cont_left = PEND_NONE;
    logic       long_done = 1'b0;
    logic       str_failed = 1'b0;
    logic       open_long = 1'b0;

    logic in_taken = 1'b0;
    int   idle_pct = IDLE_PCT;
    int   hold_reqs = 0;
    int   hold_done = 0;
    int   hold_left = 0;
    int   quiet_ticks = 0;
    int   errors = 0;

    utf8_validate_min_three_byte dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_valid       (byte_valid),
        .byte_stall       (byte_stall),
        .text_byte        (text_byte),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .verdict          (verdict),
        .malformed        (malformed),
        .saw_long_sequence(saw_long_sequence)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    task automatic scan_byte(input logic [7:0] b);
        result_t r;
        if (b == TERMINATOR)
        begin
            r.malformed         = str_failed || (cont_left != PEND_NONE);
            r.saw_long_sequence = long_done;
            r.verdict           = !r.malformed && long_done;
            verdicts_due.push_back(r);
            cont_left  = PEND_NONE;
            long_done  = 1'b0;
            str_failed = 1'b0;
            open_long  = 1'b0;
        end
        else if (!str_failed)
        begin
            if (cont_left != PEND_NONE)
            begin
                // a non-continuation byte fails the string; it is not a new lead
                if (b[7:6] != CONT_TAG)
                begin
                    str_failed = 1'b1;
                    cont_left  = PEND_NONE;
                    open_long  = 1'b0;
                end
                else
                begin
                    cont_left = cont_left - 2'd1;
                    if (cont_left == PEND_NONE)
                    begin
                        if (open_long)
                            long_done = 1'b1;
                        open_long = 1'b0;
                    end
                end
            end
            else if (b > ASCII_MAX)
            begin
                if (b <= BAD_LEAD_MAX)
                    str_failed = 1'b1;
                else if (b <= LEAD2_MAX)
                begin
                    cont_left = PEND_LEAD2;
                    open_long = 1'b0;
                end
                else if (b <= LEAD3_MAX)
                begin
                    cont_left = PEND_LEAD3;
                    open_long = 1'b1;
                end
                else if (b <= LEAD4_MAX)
                begin
                    cont_left = PEND_LEAD4;
                    open_long = 1'b1;
                end
                else
                    str_failed = 1'b1;
            end
        end
    endtask

    // mostly well-formed segments; noise bytes and cut sequences now and then
    task automatic queue_random_string();
        int n_seg;
        int kind;
        int n_cont;
        n_seg = int'($urandom_range(6));
        for (int s = 0; s < n_seg; s++)
        begin
            if ($urandom_range(99) < 10)
                byte_feed.push_back(8'($urandom_range(255, 1)));
            kind = $urandom_range(9);
            if (kind < 4)
            begin
                byte_feed.push_back(8'($urandom_range(ASCII_MAX, 1)));
                n_cont = 0;
            end
            else if (kind < 6)
            begin
                byte_feed.push_back(8'($urandom_range(LEAD2_MAX, LEAD2_MIN)));
                n_cont = 1;
            end
            else if (kind < 8)
            begin
                byte_feed.push_back(8'($urandom_range(LEAD3_MAX, LEAD3_MIN)));
                n_cont = 2;
            end
            else
            begin
                byte_feed.push_back(8'($urandom_range(LEAD4_MAX, LEAD4_MIN)));
                n_cont = 3;
            end
            if ($urandom_range(99) < 8)
                n_cont = $urandom_range(n_cont);
            for (int c = 0; c < n_cont; c++)
                byte_feed.push_back({CONT_TAG, 6'($urandom_range(63))});
        end
        byte_feed.push_back(TERMINATOR);
    endtask

    task automatic queue_random_strings(input int n_bytes);
        int start;
        start = byte_feed.size();
        while (byte_feed.size() - start < n_bytes)
            queue_random_string();
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (byte_feed.size() != 0 || byte_valid || verdicts_due.size() != 0);
    endtask

    // byte side driver
    always @(negedge clk)
    begin
        if (rst_n && (!byte_valid || in_taken))
        begin
            if (byte_feed.size() != 0 && int'($urandom_range(99)) >= idle_pct)
            begin
                byte_valid <= 1'b1;
                text_byte  <= byte_feed.pop_front();
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // result side stall, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (hold_reqs != hold_done)
        begin
            hold_done = hold_reqs;
            hold_left = HOLD_TICKS;
            result_stall <= 1'b1;
        end
        else
            result_stall <= rst_n && (int'($urandom_range(99)) < idle_pct);
    end

    // monitor: scan accepted bytes, check result beats, watch for a hang
    always @(posedge clk)
    begin
        result_t want;
        in_taken <= rst_n && byte_valid && !byte_stall;
        if (rst_n)
        begin
            quiet_ticks = quiet_ticks + 1;
            if (byte_valid && !byte_stall)
            begin
                quiet_ticks = 0;
                scan_byte(text_byte);
            end
            if (result_valid && !result_stall)
            begin
                quiet_ticks = 0;
                if (verdicts_due.size() == 0)
                begin
                    $error("result beat with no string pending");
                    errors = errors + 1;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (verdict !== want.verdict)
                    begin
                        $error("verdict: expected %0b, got %0b", want.verdict, verdict);
                        errors = errors + 1;
                    end
                    if (malformed !== want.malformed)
                    begin
                        $error("malformed: expected %0b, got %0b",
                               want.malformed, malformed);
                        errors = errors + 1;
                    end
                    if (saw_long_sequence !== want.saw_long_sequence)
                    begin
                        $error("saw_long_sequence: expected %0b, got %0b",
                               want.saw_long_sequence, saw_long_sequence);
                        errors = errors + 1;
                    end
                end
            end
            if (quiet_ticks >= QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        // empty string, ASCII then a 3-byte sequence, 2- and 4-byte extremes,
        // bad leads at both ends, bytes ignored after an error, a lead-like
        // byte where a continuation belongs, terminator inside a sequence
        byte_feed = {TERMINATOR,
                     8'h7F, 8'hE0, 8'h80, 8'hBF, TERMINATOR,
                     8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, TERMINATOR,
                     8'h80, TERMINATOR,
                     8'hFF, 8'hF5, 8'hC1, 8'hEF, TERMINATOR,
                     8'hDF, 8'hC3, TERMINATOR,
                     8'hF0, 8'h90, TERMINATOR};
        repeat (RESET_TICKS) @(negedge clk);
        rst_n = 1'b1;
        wait_drained();

        // receiver holds off while strings keep coming
        hold_reqs = hold_reqs + 1;
        queue_random_strings(250);
        wait_drained();

        idle_pct = 0;
        queue_random_strings(150);
        wait_drained();
        idle_pct = IDLE_PCT;

        queue_random_strings(300);
        wait_drained();
        repeat (TAIL_TICKS) @(posedge clk);
        #1;
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
